FILE: sv/mft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_pkg
// Shared types, codes and constants of the Manchester frame transceiver.
// ----------------------------------------------------------------------------
package mft_pkg;

  localparam int TICKS_PER_MS_DEF = 5;
  localparam int LISTEN_MAX       = 32767;
  // start bit plus 32 data bits
  localparam int FRAME_LEN        = 33;

  localparam int LISTEN_W  = 15;
  localparam int HIST_W    = 10;
  localparam int BITCNT_W  = 6;
  localparam int FRAME_W   = 32;
  localparam int RXFRAME_W = 27;
  localparam int TMO_W     = 12;
  // 12-bit timeout times a tick rate of at most 20
  localparam int MUL_W     = 17;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_LISTEN = 2'd1,
    MODE_SEND   = 2'd2,
    MODE_STOP   = 2'd3
  } cmd_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_LISTEN = 3'd1,
    ST_RECV   = 3'd2,
    ST_RECVD  = 3'd3,
    ST_SEND   = 3'd4,
    ST_SENT   = 3'd5,
    ST_ERROR  = 3'd6
  } link_state_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_TRANS = 3'd1,
    ERR_LINE_TO  = 3'd2,
    ERR_STOP     = 3'd3,
    ERR_PARITY   = 3'd4,
    ERR_RESP_TO  = 3'd5
  } err_code_t;

  typedef struct packed {
    logic      fail;
    err_code_t err;
    logic      to_recv;
    logic      to_recvd;
  } rx_status_t;

  function automatic logic even_ones(input logic [FRAME_W-1:0] v);
    return ~(^v);
  endfunction

endpackage
`default_nettype wire

FILE: sv/mft_rx.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_rx
// Listen timeout and Manchester receive state, updated once per request.
// ----------------------------------------------------------------------------
module mft_rx #(
  parameter int TICKS_PER_MS = mft_pkg::TICKS_PER_MS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               step,
  input  wire mft_pkg::cmd_mode_t                 mode,
  input  wire logic                               line,
  input  wire logic [mft_pkg::TMO_W-1:0]          timeout_ms,
  input  wire mft_pkg::link_state_t               link_mode,
  output mft_pkg::rx_status_t                     status,
  output logic [mft_pkg::RXFRAME_W-1:0]           frame
);

  logic [mft_pkg::LISTEN_W-1:0]  ticks_r,  ticks_nxt;
  logic [mft_pkg::HIST_W-1:0]    hist_r,   hist_nxt;
  logic                          await_r,  await_nxt;
  logic [mft_pkg::BITCNT_W-1:0]  bits_r,   bits_nxt;
  logic [mft_pkg::FRAME_W-1:0]   shift_r,  shift_nxt;
  logic [mft_pkg::RXFRAME_W-1:0] frame_r,  frame_nxt;

  logic [mft_pkg::MUL_W-1:0]     prod;
  logic [mft_pkg::LISTEN_W-1:0]  ticks_load;
  logic                          last;
  logic                          big4;
  logic                          big8;

  assign prod = mft_pkg::MUL_W'(timeout_ms) * mft_pkg::MUL_W'(TICKS_PER_MS);
  assign ticks_load = (prod > mft_pkg::MUL_W'(mft_pkg::LISTEN_MAX)) ?
                      mft_pkg::LISTEN_W'(mft_pkg::LISTEN_MAX) :
                      prod[mft_pkg::LISTEN_W-1:0];

  assign last = hist_r[0];
  // history counts the samples since the last transition, with a leading one
  assign big4 = |hist_r[mft_pkg::HIST_W-1:4];
  assign big8 = |hist_r[mft_pkg::HIST_W-1:8];

  always_comb begin
    ticks_nxt = ticks_r;
    hist_nxt  = hist_r;
    await_nxt = await_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    frame_nxt = frame_r;
    status    = '0;
    if (mode == mft_pkg::MODE_LISTEN) begin
      ticks_nxt = ticks_load;
      hist_nxt  = '0;
      bits_nxt  = '0;
    end else if (mode == mft_pkg::MODE_TICK && link_mode == mft_pkg::ST_LISTEN) begin
      if (ticks_r == '0) begin
        status.fail = 1'b1;
        status.err  = mft_pkg::ERR_RESP_TO;
      end else begin
        if (line) begin
          status.to_recv = 1'b1;
          shift_nxt      = '0;
          bits_nxt       = '0;
          hist_nxt       = mft_pkg::HIST_W'(1);
          await_nxt      = 1'b1;
        end
        ticks_nxt = ticks_r - mft_pkg::LISTEN_W'(1);
      end
    end else if (mode == mft_pkg::MODE_TICK && link_mode == mft_pkg::ST_RECV) begin
      if (line != last) begin
        if (await_r && big4) begin
          status.fail = 1'b1;
          status.err  = mft_pkg::ERR_NO_TRANS;
        end else if ((await_r || big4) &&
                     bits_r == mft_pkg::BITCNT_W'(mft_pkg::FRAME_LEN)) begin
          // whole frame in: check stop bit and parity
          if (!last) begin
            status.fail = 1'b1;
            status.err  = mft_pkg::ERR_STOP;
          end else if (!mft_pkg::even_ones(shift_r)) begin
            status.fail = 1'b1;
            status.err  = mft_pkg::ERR_PARITY;
          end else begin
            status.to_recvd = 1'b1;
            frame_nxt       = {shift_r[30:28], shift_r[23:0]};
          end
        end else begin
          if (await_r || big4) begin
            // mid-bit transition: the level before it is the bit
            shift_nxt = {shift_r[mft_pkg::FRAME_W-2:0], last};
            if (bits_r < mft_pkg::BITCNT_W'(mft_pkg::FRAME_LEN)) begin
              bits_nxt = bits_r + mft_pkg::BITCNT_W'(1);
            end
            await_nxt = 1'b0;
          end else begin
            await_nxt = 1'b1;
          end
          hist_nxt = {{(mft_pkg::HIST_W-2){1'b0}}, 1'b1, line};
        end
      end else if (big8) begin
        status.fail = 1'b1;
        status.err  = mft_pkg::ERR_LINE_TO;
      end else begin
        hist_nxt = {hist_r[mft_pkg::HIST_W-2:0], line};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= '0;
      hist_r  <= '0;
      await_r <= 1'b0;
      bits_r  <= '0;
      shift_r <= '0;
      frame_r <= '0;
    end else if (step) begin
      ticks_r <= ticks_nxt;
      hist_r  <= hist_nxt;
      await_r <= await_nxt;
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
      frame_r <= frame_nxt;
    end
  end

  assign frame = frame_r;

endmodule
`default_nettype wire

FILE: sv/mft_tx.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_tx
// Frame builder and half-bit Manchester line driver.
// ----------------------------------------------------------------------------
module mft_tx (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire mft_pkg::cmd_mode_t    mode,
  input  wire mft_pkg::link_state_t  link_mode,
  input  wire logic [2:0]            tx_type,
  input  wire logic [7:0]            tx_id,
  input  wire logic [7:0]            tx_value_high,
  input  wire logic [7:0]            tx_value_low,
  output logic                       line_level,
  output logic                       done
);

  logic [mft_pkg::FRAME_W-1:0]  shift_r, shift_nxt;
  logic [mft_pkg::BITCNT_W-1:0] idx_r,   idx_nxt;
  logic                         first_r, first_nxt;
  logic                         line_r,  line_nxt;

  logic [mft_pkg::FRAME_W-1:0]  frame;
  logic [mft_pkg::BITCNT_W-1:0] idx_m1;
  logic                         tx_bit;

  assign frame  = {1'b0, tx_type, 4'b0000, tx_id, tx_value_high, tx_value_low};
  assign idx_m1 = idx_r - mft_pkg::BITCNT_W'(1);
  // start and stop positions both send a one
  assign tx_bit = (idx_r == mft_pkg::BITCNT_W'(mft_pkg::FRAME_LEN) || idx_r == '0) ?
                  1'b1 : shift_r[idx_m1[4:0]];

  always_comb begin
    shift_nxt = shift_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    line_nxt  = line_r;
    done      = 1'b0;
    unique case (mode)
      mft_pkg::MODE_TICK: begin
        if (link_mode == mft_pkg::ST_SEND) begin
          line_nxt = first_r ? ~tx_bit : tx_bit;
          if (!first_r) begin
            if (idx_r == '0) begin
              done = 1'b1;
            end else begin
              idx_nxt   = idx_r - mft_pkg::BITCNT_W'(1);
              first_nxt = 1'b1;
            end
          end else begin
            first_nxt = 1'b0;
          end
        end
      end
      mft_pkg::MODE_SEND: begin
        shift_nxt = {~mft_pkg::even_ones(frame), frame[mft_pkg::FRAME_W-2:0]};
        first_nxt = 1'b1;
        idx_nxt   = mft_pkg::BITCNT_W'(mft_pkg::FRAME_LEN);
      end
      mft_pkg::MODE_STOP: begin
        line_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      idx_r   <= '0;
      first_r <= 1'b0;
      line_r  <= 1'b1;
    end else if (step) begin
      shift_r <= shift_nxt;
      idx_r   <= idx_nxt;
      first_r <= first_nxt;
      line_r  <= line_nxt;
    end
  end

  assign line_level = line_r;

endmodule
`default_nettype wire

FILE: sv/manchester_frame_transceiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// manchester_frame_transceiver
// Tick-driven Manchester frame link: listen, receive, send and stop requests.
// ----------------------------------------------------------------------------
// Every request gives exactly one result, showing the line level, link state,
// error and last good frame after it. The block takes one request per clock
// cycle while results are taken: a request goes first into an input register,
// and the link state registers update from it once no result waits untaken;
// those state registers are the result register, so a result is registered
// in the state registers behind the input register. While results are taken
// every cycle, requests are taken every cycle too; while a result waits,
// the input register still takes one more request and then in_ready drops
// until the waiting result is taken.
module manchester_frame_transceiver #(
  parameter int TICKS_PER_MS = mft_pkg::TICKS_PER_MS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic        in_line_in,
  input  wire logic [11:0] in_timeout_ms,
  input  wire logic [2:0]  in_tx_type,
  input  wire logic [7:0]  in_tx_id,
  input  wire logic [7:0]  in_tx_value_high,
  input  wire logic [7:0]  in_tx_value_low,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_line_out,
  output logic [2:0]       out_link_state,
  output logic [2:0]       out_error_code,
  output logic [2:0]       out_rx_type,
  output logic [7:0]       out_rx_id,
  output logic [7:0]       out_rx_value_high,
  output logic [7:0]       out_rx_value_low
);

  logic                  in_valid_r;
  mft_pkg::cmd_mode_t    mode_r;
  logic                  line_r;
  logic [11:0]           timeout_r;
  logic [2:0]            tx_type_r;
  logic [7:0]            tx_id_r;
  logic [7:0]            tx_vh_r;
  logic [7:0]            tx_vl_r;

  logic                  out_valid_r, out_valid_nxt;
  mft_pkg::link_state_t  link_mode_r, link_mode_nxt;
  mft_pkg::err_code_t    err_r,       err_nxt;

  logic                  step;
  logic                  slot_free;
  mft_pkg::rx_status_t   rx_status;
  logic [26:0]           rx_frame;
  logic                  tx_line;
  logic                  tx_done;

  assign slot_free = !out_valid_r || out_ready;
  assign step      = in_valid_r && slot_free;
  assign in_ready  = !in_valid_r || slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r    <= mft_pkg::cmd_mode_t'(in_mode);
      line_r    <= in_line_in;
      timeout_r <= in_timeout_ms;
      tx_type_r <= in_tx_type;
      tx_id_r   <= in_tx_id;
      tx_vh_r   <= in_tx_value_high;
      tx_vl_r   <= in_tx_value_low;
    end
  end

  mft_rx #(
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .mode       (mode_r),
    .line       (line_r),
    .timeout_ms (timeout_r),
    .link_mode  (link_mode_r),
    .status     (rx_status),
    .frame      (rx_frame)
  );

  mft_tx u_tx (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .mode          (mode_r),
    .link_mode     (link_mode_r),
    .tx_type       (tx_type_r),
    .tx_id         (tx_id_r),
    .tx_value_high (tx_vh_r),
    .tx_value_low  (tx_vl_r),
    .line_level    (tx_line),
    .done          (tx_done)
  );

  always_comb begin
    link_mode_nxt = link_mode_r;
    err_nxt       = err_r;
    unique case (mode_r)
      mft_pkg::MODE_TICK: begin
        if (link_mode_r == mft_pkg::ST_LISTEN || link_mode_r == mft_pkg::ST_RECV) begin
          if (rx_status.fail) begin
            link_mode_nxt = mft_pkg::ST_ERROR;
            err_nxt       = rx_status.err;
          end else if (rx_status.to_recv) begin
            link_mode_nxt = mft_pkg::ST_RECV;
          end else if (rx_status.to_recvd) begin
            link_mode_nxt = mft_pkg::ST_RECVD;
          end
        end else if (link_mode_r == mft_pkg::ST_SEND && tx_done) begin
          link_mode_nxt = mft_pkg::ST_SENT;
        end
      end
      mft_pkg::MODE_LISTEN: link_mode_nxt = mft_pkg::ST_LISTEN;
      mft_pkg::MODE_SEND:   link_mode_nxt = mft_pkg::ST_SEND;
      mft_pkg::MODE_STOP:   link_mode_nxt = mft_pkg::ST_IDLE;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      link_mode_r <= mft_pkg::ST_IDLE;
      err_r       <= mft_pkg::ERR_NONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        link_mode_r <= link_mode_nxt;
        err_r       <= err_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_out      = tx_line;
  assign out_link_state    = link_mode_r;
  assign out_error_code    = (link_mode_r == mft_pkg::ST_ERROR) ? err_r : mft_pkg::ERR_NONE;
  assign out_rx_type       = rx_frame[26:24];
  assign out_rx_id         = rx_frame[23:16];
  assign out_rx_value_high = rx_frame[15:8];
  assign out_rx_value_low  = rx_frame[7:0];

`ifndef ASSERT_OFF
  a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
    step && mode_r == mft_pkg::MODE_STOP |=>
      tx_line && link_mode_r == mft_pkg::ST_IDLE)
    else $error("stop request did not return the link to idle");

  a_frame_on_recvd: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(rx_frame) |-> link_mode_r == mft_pkg::ST_RECVD)
    else $error("received frame changed without a good frame");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(step) |-> $stable(link_mode_r) && $stable(err_r))
    else $error("link state changed without a request");

  a_error_coded: assert property (@(posedge clk) disable iff (!rst_n)
    link_mode_r == mft_pkg::ST_ERROR |-> err_r != mft_pkg::ERR_NONE)
    else $error("error state without an error code");
`endif

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Request-level test of the Manchester frame transceiver. A behavioral copy of
// the link (listen timeout, receive decoder, send encoder) predicts the status
// after every request; each status the block returns is compared against it.
// Stimulus covers idle and error corners, complete send frames, received
// frames with and without faults, random request mixes and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HOLD_CYCLES = 64;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam longint LIMIT_NS = 4_000_000;

  typedef struct {
    mft_pkg::cmd_mode_t mode;
    logic        line;
    logic [11:0] tmo;
    logic [2:0]  typ;
    logic [7:0]  id;
    logic [7:0]  vhi;
    logic [7:0]  vlo;
  } link_req_t;

  typedef struct {
    logic        line;
    mft_pkg::link_state_t state;
    mft_pkg::err_code_t   err;
    logic [2:0]  typ;
    logic [7:0]  id;
    logic [7:0]  vhi;
    logic [7:0]  vlo;
  } link_status_t;

  typedef enum int {
    FLAW_NONE, FLAW_PARITY, FLAW_STOP, FLAW_STRETCH, FLAW_STUCK, FLAW_GLITCH,
    FLAW_ABORT
  } rx_flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = mft_pkg::MODE_TICK;
  logic        in_line_in = 1'b0;
  logic [11:0] in_timeout_ms = '0;
  logic [2:0]  in_tx_type = '0;
  logic [7:0]  in_tx_id = '0;
  logic [7:0]  in_tx_value_high = '0;
  logic [7:0]  in_tx_value_low = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_line_out;
  logic [2:0]  out_link_state;
  logic [2:0]  out_error_code;
  logic [2:0]  out_rx_type;
  logic [7:0]  out_rx_id;
  logic [7:0]  out_rx_value_high;
  logic [7:0]  out_rx_value_low;

  // behavioral copy of the link
  mft_pkg::link_state_t lnk_state;
  mft_pkg::err_code_t   lnk_err;
  logic [14:0] resp_ticks;
  logic [9:0]  hist;
  logic        want_mid;
  logic [5:0]  bit_cnt;
  logic [31:0] shreg;
  logic [26:0] rx_frame;
  logic [31:0] tx_frame;
  logic [5:0]  tx_idx;
  logic        tx_first;
  logic        line_lvl;

  link_status_t pending_status[$];
  logic         line_wave[$];

  bit no_gaps = 1'b0;
  bit hold_off_req = 1'b0;
  int hold_cnt;
  int mismatch_cnt = 0;
  int req_cnt = 0;
  int status_cnt = 0;
  int good_rx_cnt = 0;
  int sent_cnt = 0;
  int err_seen[8];

  manchester_frame_transceiver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_line_in       (in_line_in),
    .in_timeout_ms    (in_timeout_ms),
    .in_tx_type       (in_tx_type),
    .in_tx_id         (in_tx_id),
    .in_tx_value_high (in_tx_value_high),
    .in_tx_value_low  (in_tx_value_low),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_out     (out_line_out),
    .out_link_state   (out_link_state),
    .out_error_code   (out_error_code),
    .out_rx_type      (out_rx_type),
    .out_rx_id        (out_rx_id),
    .out_rx_value_high(out_rx_value_high),
    .out_rx_value_low (out_rx_value_low)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void reset_link_model();
    lnk_state  = mft_pkg::ST_IDLE;
    lnk_err    = mft_pkg::ERR_NONE;
    resp_ticks = '0;
    hist       = '0;
    want_mid   = 1'b0;
    bit_cnt    = '0;
    shreg      = '0;
    rx_frame   = '0;
    tx_frame   = '0;
    tx_idx     = '0;
    tx_first   = 1'b0;
    line_lvl   = 1'b1;
    foreach (err_seen[i]) err_seen[i] = 0;
  endfunction

  function automatic void link_fail(input mft_pkg::err_code_t code);
    lnk_state = mft_pkg::ST_ERROR;
    lnk_err   = code;
  endfunction

  function automatic void listen_tick(input logic v);
    if (resp_ticks == '0) begin
      link_fail(mft_pkg::ERR_RESP_TO);
    end else begin
      if (v) begin
        lnk_state = mft_pkg::ST_RECV;
        shreg     = '0;
        bit_cnt   = '0;
        hist      = 10'd1;
        want_mid  = 1'b1;
      end
      resp_ticks = resp_ticks - 15'd1;
    end
  endfunction

  // a transition is mid-bit when one is due or the level has held long enough
  function automatic void rx_tick(input logic v);
    logic last;
    last = hist[0];
    if (v != last) begin
      if (want_mid && hist > 10'hF) begin
        link_fail(mft_pkg::ERR_NO_TRANS);
        return;
      end
      if (want_mid || hist > 10'hF) begin
        if (bit_cnt == 6'(mft_pkg::FRAME_LEN)) begin
          if (!last) begin
            link_fail(mft_pkg::ERR_STOP);
          end else if (^shreg) begin
            link_fail(mft_pkg::ERR_PARITY);
          end else begin
            lnk_state = mft_pkg::ST_RECVD;
            rx_frame  = {shreg[30:28], shreg[23:0]};
          end
          return;
        end
        shreg = {shreg[30:0], last};
        if (bit_cnt < 6'(mft_pkg::FRAME_LEN)) bit_cnt = bit_cnt + 6'd1;
        want_mid = 1'b0;
      end else begin
        want_mid = 1'b1;
      end
      hist = 10'd1;
    end else if (hist > 10'hFF) begin
      link_fail(mft_pkg::ERR_LINE_TO);
      return;
    end
    hist = {hist[8:0], v};
  endfunction

  // start and stop bits are ones; data goes out msb first
  function automatic void tx_tick();
    logic b;
    if (tx_idx == 6'(mft_pkg::FRAME_LEN) || tx_idx == 6'd0) b = 1'b1;
    else b = tx_frame[5'(tx_idx - 6'd1)];
    line_lvl = tx_first ? ~b : b;
    if (!tx_first) begin
      if (tx_idx == 6'd0) begin
        lnk_state = mft_pkg::ST_SENT;
        return;
      end
      tx_idx   = tx_idx - 6'd1;
      tx_first = 1'b1;
    end else begin
      tx_first = 1'b0;
    end
  endfunction

  task automatic predict_link_status(input link_req_t r, output link_status_t s);
    mft_pkg::link_state_t prev;
    logic [31:0] ticks;
    logic [31:0] word;
    prev = lnk_state;
    case (r.mode)
      mft_pkg::MODE_TICK: begin
        if (lnk_state == mft_pkg::ST_LISTEN) listen_tick(r.line);
        else if (lnk_state == mft_pkg::ST_RECV) rx_tick(r.line);
        else if (lnk_state == mft_pkg::ST_SEND) tx_tick();
      end
      mft_pkg::MODE_LISTEN: begin
        ticks = 32'(r.tmo) * 32'(mft_pkg::TICKS_PER_MS_DEF);
        resp_ticks = (ticks > 32'(mft_pkg::LISTEN_MAX)) ?
                     15'(mft_pkg::LISTEN_MAX) : ticks[14:0];
        lnk_state = mft_pkg::ST_LISTEN;
        hist      = '0;
        bit_cnt   = '0;
      end
      mft_pkg::MODE_SEND: begin
        word = {1'b0, r.typ, 4'h0, r.id, r.vhi, r.vlo};
        word[31] = ^word;
        tx_frame  = word;
        tx_first  = 1'b1;
        tx_idx    = 6'(mft_pkg::FRAME_LEN);
        lnk_state = mft_pkg::ST_SEND;
      end
      default: begin
        lnk_state = mft_pkg::ST_IDLE;
        line_lvl  = 1'b1;
      end
    endcase
    if (lnk_state != prev) begin
      if (lnk_state == mft_pkg::ST_RECVD) good_rx_cnt++;
      if (lnk_state == mft_pkg::ST_SENT) sent_cnt++;
      if (lnk_state == mft_pkg::ST_ERROR) err_seen[lnk_err]++;
    end
    s.line  = line_lvl;
    s.state = lnk_state;
    s.err   = (lnk_state == mft_pkg::ST_ERROR) ? lnk_err : mft_pkg::ERR_NONE;
    s.typ   = rx_frame[26:24];
    s.id    = rx_frame[23:16];
    s.vhi   = rx_frame[15:8];
    s.vlo   = rx_frame[7:0];
  endtask

  // ----------------------------------------------------------------- checking

  task automatic check_link_status();
    link_status_t want;
    link_status_t got;
    got.line  = out_line_out;
    got.state = mft_pkg::link_state_t'(out_link_state);
    got.err   = mft_pkg::err_code_t'(out_error_code);
    got.typ   = out_rx_type;
    got.id    = out_rx_id;
    got.vhi   = out_rx_value_high;
    got.vlo   = out_rx_value_low;
    status_cnt++;
    if (pending_status.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("[%0t] status with no request pending: state=%0d err=%0d", $time,
                 out_link_state, out_error_code);
    end else begin
      want = pending_status.pop_front();
      if (got.line !== want.line || got.state !== want.state || got.err !== want.err ||
          got.typ !== want.typ || got.id !== want.id || got.vhi !== want.vhi ||
          got.vlo !== want.vlo) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("[%0t] status %0d mismatch", $time, status_cnt);
          $display("  expected line=%b state=%0d err=%0d rx=%0d/%h/%h/%h", want.line,
                   want.state, want.err, want.typ, want.id, want.vhi, want.vlo);
          $display("  actual   line=%b state=%0d err=%0d rx=%0d/%h/%h/%h", got.line,
                   got.state, got.err, got.typ, got.id, got.vhi, got.vlo);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_link_status();
  end

  // result side: random stalls, or a long hold when a test asks for one
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= no_gaps || ($urandom_range(99) >= 23);
    end
  end

  // ----------------------------------------------------------------- requests

  function automatic link_req_t random_request(input mft_pkg::cmd_mode_t m);
    link_req_t r;
    r.mode = m;
    r.line = 1'($urandom_range(1));
    r.tmo  = 12'($urandom_range(4095));
    r.typ  = 3'($urandom_range(7));
    r.id   = 8'($urandom_range(255));
    r.vhi  = 8'($urandom_range(255));
    r.vlo  = 8'($urandom_range(255));
    return r;
  endfunction

  task automatic put_request(input link_req_t r);
    link_status_t s;
    if (!no_gaps && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 23);
    end
    in_valid         <= 1'b1;
    in_mode          <= r.mode;
    in_line_in       <= r.line;
    in_timeout_ms    <= r.tmo;
    in_tx_type       <= r.typ;
    in_tx_id         <= r.id;
    in_tx_value_high <= r.vhi;
    in_tx_value_low  <= r.vlo;
    do @(posedge clk); while (!in_ready);
    predict_link_status(r, s);
    pending_status.push_back(s);
    req_cnt++;
  endtask

  task automatic put_tick(input logic v);
    link_req_t r;
    r = random_request(mft_pkg::MODE_TICK);
    r.line = v;
    put_request(r);
  endtask

  task automatic put_listen(input logic [11:0] tmo);
    link_req_t r;
    r = random_request(mft_pkg::MODE_LISTEN);
    r.tmo = tmo;
    put_request(r);
  endtask

  task automatic put_send(input logic [2:0] typ, input logic [7:0] id,
                          input logic [7:0] vhi, input logic [7:0] vlo);
    link_req_t r;
    r = random_request(mft_pkg::MODE_SEND);
    r.typ = typ;
    r.id  = id;
    r.vhi = vhi;
    r.vlo = vlo;
    put_request(r);
  endtask

  task automatic put_stop();
    put_request(random_request(mft_pkg::MODE_STOP));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  // each bit: first half at the bit level, second half inverted, 2 or 3 samples each
  task automatic build_line_wave(input logic [31:0] word, input logic stop_lvl);
    logic [33:0] bits;
    bits = {1'b1, word, stop_lvl};
    line_wave.delete();
    for (int i = 33; i >= 0; i--) begin
      repeat ($urandom_range(2, 3)) line_wave.push_back(bits[i]);
      repeat ($urandom_range(2, 3)) line_wave.push_back(~bits[i]);
    end
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_corner_cases();
    put_tick(1'b1);
    put_tick(1'b0);
    put_stop();
    // zero timeout fails on the first listening tick; error state ignores ticks
    put_listen(12'h000);
    put_tick(1'b0);
    put_tick(1'b1);
    // largest timeout, then the line stuck high
    put_listen(12'hFFF);
    repeat (11) put_tick(1'b1);
    put_send(3'h7, 8'hFF, 8'hFF, 8'hFF);
    repeat (3) put_tick(1'b0);
    // aborting a send with a stop drives the line back high
    put_listen(12'h001);
    put_send(3'h0, 8'h00, 8'h00, 8'h00);
    put_tick(1'b1);
    put_stop();
  endtask

  task automatic test_send_frames();
    for (int f = 0; f < 2; f++) begin
      no_gaps = (f == 0);
      put_request(random_request(mft_pkg::MODE_SEND));
      repeat (68 + $urandom_range(0, 3)) put_tick(1'($urandom_range(1)));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_receive_frames();
    logic [31:0] word;
    rx_flaw_t    flaw;
    int          pos;
    for (int f = 0; f < 5; f++) begin
      if (f < 3) flaw = rx_flaw_t'(f);
      else if ($urandom_range(1) == 0) flaw = FLAW_NONE;
      else flaw = rx_flaw_t'($urandom_range(3, 6));
      word = $urandom();
      word[31] = ^word[30:0];
      if (flaw == FLAW_PARITY) word[31] = ~word[31];
      build_line_wave(word, (flaw == FLAW_STOP) ? 1'b0 : 1'b1);
      pos = int'($urandom_range(4, line_wave.size() - 2));
      case (flaw)
        FLAW_STRETCH: repeat ($urandom_range(2, 4)) line_wave.insert(pos, line_wave[pos]);
        FLAW_STUCK: begin
          line_wave = line_wave[0:pos];
          repeat (12) line_wave.push_back(line_wave[pos]);
        end
        FLAW_GLITCH: line_wave[pos] = ~line_wave[pos];
        FLAW_ABORT: line_wave = line_wave[0:pos];
        default: ;
      endcase
      put_listen(12'($urandom_range(1, 4095)));
      repeat ($urandom_range(0, 4)) put_tick(1'b0);
      foreach (line_wave[i]) put_tick(line_wave[i]);
      if (flaw == FLAW_ABORT) begin
        put_request(random_request(mft_pkg::cmd_mode_t'($urandom_range(1, 3))));
        repeat ($urandom_range(2, 8)) put_tick(1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(0, 3)) put_tick(1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random_requests();
    link_req_t r;
    int        pick;
    for (int i = 0; i < 60; i++) begin
      pick = int'($urandom_range(99));
      if (pick < 70) begin
        put_tick(1'($urandom_range(1)));
      end else if (pick < 80) begin
        r = random_request(mft_pkg::MODE_LISTEN);
        if ($urandom_range(1) == 0) r.tmo = 12'($urandom_range(2));
        put_request(r);
      end else if (pick < 90) begin
        put_request(random_request(mft_pkg::MODE_SEND));
      end else begin
        put_stop();
      end
    end
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    hold_off_req = 1'b1;
    put_listen(12'd2);
    repeat (14) put_tick(1'($urandom_range(1)));
    wait_drained();
    put_request(random_request(mft_pkg::MODE_SEND));
    repeat (10) put_tick(1'($urandom_range(1)));
    no_gaps = 1'b0;
    wait_drained();
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    reset_link_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_cases();
    test_send_frames();
    test_receive_frames();
    test_random_requests();
    test_backpressure();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d statuses: %0d frames received, %0d frames sent",
             req_cnt, status_cnt, good_rx_cnt, sent_cnt);
    $display("errors provoked: no transition %0d, line timeout %0d, stop bit %0d, parity %0d,"
             , err_seen[mft_pkg::ERR_NO_TRANS], err_seen[mft_pkg::ERR_LINE_TO],
             err_seen[mft_pkg::ERR_STOP], err_seen[mft_pkg::ERR_PARITY]);
    $display("  response timeout %0d; mismatches %0d, statuses still pending %0d",
             err_seen[mft_pkg::ERR_RESP_TO], mismatch_cnt, pending_status.size());
    if (mismatch_cnt == 0 && pending_status.size() == 0) begin
      $display("manchester_frame_transceiver test passed");
    end else begin
      $display("manchester_frame_transceiver test failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d statuses pending", pending_status.size());
    $display("manchester_frame_transceiver test failed");
    $finish;
  end

endmodule

FILE: files.f
sv/mft_pkg.sv
sv/mft_rx.sv
sv/mft_tx.sv
sv/manchester_frame_transceiver.sv
test/tb_top.sv
